### hw/rtl/eg_pkg.sv
// Shared constants, codes, control structs and helper functions for the
// epsilon-greedy action selector. No dependencies.
package eg_pkg;

  localparam int NUM_STATES     = 64;
  localparam int NUM_ACTIONS    = 4;
  localparam int NUM_OBJECTIVES = 2;
  localparam int Q_WIDTH        = 16;

  // Fixed field widths of the ports
  localparam int STATE_W   = 6;
  localparam int ACTION_W  = 2;
  localparam int OBJ_IDX_W = 2;
  localparam int W_WIDTH   = 16;
  localparam int EPS_W     = 16;
  localparam int RPICK_W   = 8;
  localparam int TR_W      = STATE_W + 1;

  localparam int TR_DEPTH  = NUM_STATES * NUM_ACTIONS;
  localparam int Q_DEPTH   = TR_DEPTH * NUM_OBJECTIVES;
  localparam int TR_AW     = $clog2(TR_DEPTH);
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int ACT_W     = $clog2(NUM_ACTIONS);
  localparam int OBJ_W     = (NUM_OBJECTIVES > 1) ? $clog2(NUM_OBJECTIVES) : 1;
  localparam int PROD_W    = Q_WIDTH + W_WIDTH;
  localparam int SUM_W     = PROD_W + 2;
  localparam int CNT_W     = 3;
  localparam int SWEEP_LEN = NUM_ACTIONS * NUM_OBJECTIVES;

  localparam logic [EPS_W-1:0]   EPS_RESET    = 16'd58982;  // 0.90
  localparam logic [EPS_W-1:0]   EPS_DECAY    = 16'd63570;  // 0.97
  localparam logic [EPS_W-1:0]   EPS_FLOOR    = 16'd19661;  // 0.30
  localparam logic [W_WIDTH-1:0] WEIGHT_RESET = 16'd256;    // 1.0 in Q8.8

  typedef enum logic [2:0] {
    KIND_LOAD_TR     = 3'd0,
    KIND_LOAD_Q      = 3'd1,
    KIND_ACT         = 3'd2,
    KIND_RANDOM      = 3'd3,
    KIND_NEXT_GREEDY = 3'd4,
    KIND_DECAY       = 3'd5,
    KIND_FLOOR       = 3'd6,
    KIND_RESTART     = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_ACTION = 2'd1,
    STATUS_ACK       = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_WEIGHT0   = 3'd0,
    CFG_WEIGHT1   = 3'd1,
    CFG_WEIGHT2   = 3'd2,
    CFG_WEIGHT3   = 3'd3,
    CFG_EPS_START = 3'd4
  } cfg_idx_t;

  // Tag that travels with one Q read through the scoring pipeline
  typedef struct packed {
    logic             vld;
    logic [ACT_W-1:0] act;
    logic [OBJ_W-1:0] obj;
    logic             first;
    logic             last;
  } q_tag_t;

  typedef struct packed {
    logic             clear;
    q_tag_t           q_tag;
    logic             tr_vld;
    logic [ACT_W-1:0] tr_act;
  } score_ctl_t;

  typedef struct packed {
    logic [NUM_ACTIONS-1:0]              valid_mask;
    logic [NUM_ACTIONS-1:0][STATE_W-1:0] next_st;
    logic [ACT_W-1:0]                    best_act;
    logic                                any_nz;
  } score_res_t;

  // 4 = 1 mod 3, so the base-4 digit sum keeps the residue
  function automatic logic [1:0] mod3_u8(input logic [RPICK_W-1:0] v);
    logic [3:0] s;
    logic [1:0] r;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    case (s) inside
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
      default:                              r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/eg_tables.sv
// Transition table and Q table: single-port-write, single-port-read
// synchronous memories with registered read data. Uses eg_pkg.
module eg_tables import eg_pkg::*; (
  input  logic                      clk,
  input  logic                      tr_we,
  input  logic [TR_AW-1:0]          tr_waddr,
  input  logic [TR_W-1:0]           tr_wdata,
  input  logic                      tr_re,
  input  logic [TR_AW-1:0]          tr_raddr,
  output logic [TR_W-1:0]           tr_rdata,
  input  logic                      q_we,
  input  logic [Q_AW-1:0]           q_waddr,
  input  logic [Q_WIDTH-1:0]        q_wdata,
  input  logic                      q_re,
  input  logic [Q_AW-1:0]           q_raddr,
  output logic [Q_WIDTH-1:0]        q_rdata
);

  logic [TR_W-1:0]    tr_mem [TR_DEPTH];
  logic [Q_WIDTH-1:0] q_mem  [Q_DEPTH];

  always_ff @(posedge clk) begin
    if (tr_we) begin
      tr_mem[tr_waddr] <= tr_wdata;
    end
    if (tr_re) begin
      tr_rdata <= tr_mem[tr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rdata <= q_mem[q_raddr];
    end
  end

endmodule

### hw/rtl/eg_score.sv
// Scoring pipeline: weights each Q read, sums objectives per action and keeps
// the first maximum, valid mask and next states of the swept state. Uses eg_pkg.
module eg_score import eg_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  score_ctl_t                     ctl,
  input  logic [3:0][W_WIDTH-1:0]        weights,
  input  logic [Q_WIDTH-1:0]             q_rdata,
  input  logic [TR_W-1:0]                tr_rdata,
  output score_res_t                     res
);

  q_tag_t                              tag1_r, tag2_r;
  logic                                tr_vld_r;
  logic [ACT_W-1:0]                    tr_act_r;
  logic signed [PROD_W-1:0]            prod_r;
  logic signed [PROD_W-1:0]            prod_nxt;
  logic signed [SUM_W-1:0]             acc_r, best_r, sum_nxt;
  logic                                have_r, any_nz_r;
  logic [ACT_W-1:0]                    best_act_r;
  logic [NUM_ACTIONS-1:0]              valid_r;
  logic [NUM_ACTIONS-1:0][STATE_W-1:0] ns_r;
  logic signed [Q_WIDTH-1:0]           q_s;
  logic signed [W_WIDTH-1:0]           w_s;
  logic                                eval;

  assign q_s      = $signed(q_rdata);
  assign w_s      = $signed(weights[2'(tag1_r.obj)]);
  assign prod_nxt = q_s * w_s;
  assign sum_nxt  = (tag2_r.first ? SUM_W'(0) : acc_r) + SUM_W'(prod_r);
  assign eval     = tag2_r.vld && tag2_r.last && valid_r[tag2_r.act];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r   <= '0;
      tag2_r   <= '0;
      tr_vld_r <= 1'b0;
      have_r   <= 1'b0;
      any_nz_r <= 1'b0;
    end else begin
      // align tags with the memory output, then with the product register
      tag1_r   <= ctl.q_tag;
      tag2_r   <= tag1_r;
      tr_vld_r <= ctl.tr_vld;
      if (ctl.clear) begin
        have_r   <= 1'b0;
        any_nz_r <= 1'b0;
      end else if (eval) begin
        if (sum_nxt != '0) begin
          any_nz_r <= 1'b1;
        end
        if (!have_r || sum_nxt > best_r) begin
          have_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    tr_act_r <= ctl.tr_act;
    prod_r   <= prod_nxt;
    if (tag2_r.vld) begin
      acc_r <= sum_nxt;
    end
    if (!ctl.clear && eval && (!have_r || sum_nxt > best_r)) begin
      best_r     <= sum_nxt;
      best_act_r <= tag2_r.act;
    end
    if (tr_vld_r) begin
      valid_r[tr_act_r] <= tr_rdata[TR_W-1];
      ns_r[tr_act_r]    <= tr_rdata[STATE_W-1:0];
    end
  end

  assign res.valid_mask = valid_r;
  assign res.next_st    = ns_r;
  assign res.best_act   = best_act_r;
  assign res.any_nz     = any_nz_r;

endmodule

### hw/rtl/epsilon_greedy_action_select.sv
// Top level of the epsilon-greedy action selector: command sequencer, config
// and epsilon registers, random pick. Uses eg_pkg, eg_tables and eg_score.
//
// Load, decay, floor and restart commands complete at the start transfer:
// busy stays low and the acknowledgement is strobed on out_valid the next
// cycle, so these can be issued every cycle. Act, forced random and next
// greedy commands raise busy while the sequencer steps through its sweep,
// drain and finish states, and strobe their result once busy is low again.
// The Q table's single read port sets this: the sweep reads one Q entry per
// cycle, followed by a multiply and accumulate tail and a decision state.
// Every result is shown for exactly one cycle; the receiver must take it.
// Tables are not cleared by reset, so every entry must be loaded before any
// selection command reads it.
module epsilon_greedy_action_select import eg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_kind,
  input  logic [STATE_W-1:0]        in_state_index,
  input  logic [ACTION_W-1:0]       in_action_index,
  input  logic [OBJ_IDX_W-1:0]      in_objective_index,
  input  logic signed [15:0]        in_q_value,
  input  logic [STATE_W-1:0]        in_target_state,
  input  logic                      in_target_valid,
  input  logic [EPS_W-1:0]          in_rand_uniform,
  input  logic [RPICK_W-1:0]        in_rand_pick,
  output logic                      out_valid,
  output logic [ACTION_W-1:0]       out_chosen_action,
  output logic [STATE_W-1:0]        out_next_state,
  output logic                      out_explored,
  output logic [1:0]                out_status,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [15:0]               cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                   state_r;
  kind_t                    kind_in, kind_r;
  logic                     explore_r, oor_r, drain_r;
  logic [RPICK_W-1:0]       rpick_r;
  logic [ACT_W-1:0]         act_cnt_r;
  logic [OBJ_W-1:0]         obj_cnt_r;
  logic [Q_AW-1:0]          q_addr_r;
  logic [TR_AW-1:0]         tr_addr_r;
  logic [EPS_W-1:0]         eps_r, eps_start_r;
  logic [2*EPS_W-1:0]       eps_prod;
  logic [STATE_W-1:0]       pending_r;
  logic [3:0][W_WIDTH-1:0]  weight_r;

  logic                     out_valid_r, out_explored_r;
  logic [ACTION_W-1:0]      out_action_r;
  logic [STATE_W-1:0]       out_ns_r;
  status_t                  out_status_r;

  logic                     accept, sel_kind, ack_kind;
  logic [STATE_W-1:0]       src_in;
  logic                     ld_s_ok, ld_a_ok, ld_o_ok;
  logic                     tr_we, q_we, tr_re, q_re;
  logic [TR_AW-1:0]         tr_waddr;
  logic [Q_AW-1:0]          q_waddr;
  logic [TR_W-1:0]          tr_rdata;
  logic [Q_WIDTH-1:0]       q_rdata;
  logic                     obj_last, act_last;
  score_ctl_t               sctl;
  score_res_t               sres;

  logic [CNT_W-1:0]         vcount, seen;
  logic [1:0]               target;
  logic [ACT_W-1:0]         pick, fin_act;
  logic                     found, rand_mode, fin_none;

  assign kind_in  = kind_t'(in_kind);
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign sel_kind = (kind_in == KIND_ACT) || (kind_in == KIND_RANDOM) ||
                    (kind_in == KIND_NEXT_GREEDY);
  assign ack_kind = !sel_kind;
  assign src_in   = (kind_in == KIND_NEXT_GREEDY) ? pending_r : in_state_index;
  assign eps_prod = eps_r * EPS_DECAY;

  // ---------------- table writes (loads) ----------------
  assign ld_s_ok  = int'(in_state_index) < NUM_STATES;
  assign ld_a_ok  = int'(in_action_index) < NUM_ACTIONS;
  assign ld_o_ok  = int'(in_objective_index) < NUM_OBJECTIVES;
  assign tr_we    = accept && (kind_in == KIND_LOAD_TR) && ld_s_ok && ld_a_ok;
  assign q_we     = accept && (kind_in == KIND_LOAD_Q) && ld_s_ok && ld_a_ok && ld_o_ok;
  assign tr_waddr = TR_AW'(int'(in_state_index) * NUM_ACTIONS + int'(in_action_index));
  assign q_waddr  = Q_AW'((int'(in_state_index) * NUM_ACTIONS + int'(in_action_index))
                          * NUM_OBJECTIVES + int'(in_objective_index));

  // ---------------- sweep issue ----------------
  assign obj_last = (obj_cnt_r == OBJ_W'(NUM_OBJECTIVES - 1));
  assign act_last = (act_cnt_r == ACT_W'(NUM_ACTIONS - 1));
  assign q_re     = (state_r == ST_SWEEP);
  assign tr_re    = q_re && (obj_cnt_r == '0);

  assign sctl.clear       = accept && sel_kind;
  assign sctl.q_tag.vld   = q_re;
  assign sctl.q_tag.act   = act_cnt_r;
  assign sctl.q_tag.obj   = obj_cnt_r;
  assign sctl.q_tag.first = (obj_cnt_r == '0);
  assign sctl.q_tag.last  = obj_last;
  assign sctl.tr_vld      = tr_re;
  assign sctl.tr_act      = act_cnt_r;

  eg_tables u_tables (
    .clk      (clk),
    .tr_we    (tr_we),
    .tr_waddr (tr_waddr),
    .tr_wdata ({in_target_valid, in_target_state}),
    .tr_re    (tr_re),
    .tr_raddr (tr_addr_r),
    .tr_rdata (tr_rdata),
    .q_we     (q_we),
    .q_waddr  (q_waddr),
    .q_wdata  (Q_WIDTH'(in_q_value)),
    .q_re     (q_re),
    .q_raddr  (q_addr_r),
    .q_rdata  (q_rdata)
  );

  eg_score u_score (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sctl),
    .weights  (weight_r),
    .q_rdata  (q_rdata),
    .tr_rdata (tr_rdata),
    .res      (sres)
  );

  // ---------------- decision ----------------
  always_comb begin
    vcount = '0;
    for (int a = 0; a < NUM_ACTIONS; a++) begin
      vcount = vcount + CNT_W'(sres.valid_mask[a]);
    end
    case (vcount)
      3'd1:    target = 2'd0;
      3'd2:    target = {1'b0, rpick_r[0]};
      3'd3:    target = mod3_u8(rpick_r);
      default: target = rpick_r[1:0];
    endcase
    // pick the valid action whose rank among valid actions equals target
    pick  = '0;
    found = 1'b0;
    seen  = '0;
    for (int a = 0; a < NUM_ACTIONS; a++) begin
      if (sres.valid_mask[a]) begin
        if (!found && seen == CNT_W'(target)) begin
          pick  = ACT_W'(a);
          found = 1'b1;
        end
        seen = seen + CNT_W'(1);
      end
    end
    rand_mode = (kind_r == KIND_RANDOM) || ((kind_r == KIND_ACT) && explore_r) ||
                !sres.any_nz;
    fin_act   = rand_mode ? pick : sres.best_act;
    fin_none  = oor_r || (rand_mode && vcount == '0);
  end

  // ---------------- config registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r    <= {4{WEIGHT_RESET}};
      eps_start_r <= EPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WEIGHT0:   weight_r[0] <= cfg_wdata;
        CFG_WEIGHT1:   weight_r[1] <= cfg_wdata;
        CFG_WEIGHT2:   weight_r[2] <= cfg_wdata;
        CFG_WEIGHT3:   weight_r[3] <= cfg_wdata;
        CFG_EPS_START: eps_start_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      eps_r        <= EPS_RESET;
      pending_r    <= '0;
      out_valid_r  <= 1'b0;
      kind_r       <= KIND_LOAD_TR;
      drain_r      <= 1'b0;
      act_cnt_r    <= '0;
      obj_cnt_r    <= '0;
    end else begin
      // acknowledge-only commands finish at the transfer
      out_valid_r <= (accept && ack_kind) || (state_r == ST_FINISH);
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            kind_r    <= kind_in;
            act_cnt_r <= '0;
            obj_cnt_r <= '0;
            if (sel_kind) begin
              state_r <= ST_SWEEP;
            end else begin
              unique case (kind_in)
                KIND_DECAY:   eps_r <= eps_prod[2*EPS_W-1:EPS_W];
                KIND_FLOOR:   if (eps_r <= EPS_FLOOR) eps_r <= EPS_FLOOR;
                KIND_RESTART: eps_r <= eps_start_r;
                default:      ;
              endcase
            end
          end
        end
        ST_SWEEP: begin
          if (obj_last) begin
            obj_cnt_r <= '0;
            act_cnt_r <= act_cnt_r + ACT_W'(1);
            if (act_last) begin
              state_r <= ST_DRAIN;
              drain_r <= 1'b0;
            end
          end else begin
            obj_cnt_r <= obj_cnt_r + OBJ_W'(1);
          end
        end
        ST_DRAIN: begin
          // wait for the last product to reach the compare
          drain_r <= 1'b1;
          if (drain_r) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state_r     <= ST_IDLE;
          if (!fin_none && kind_r != KIND_NEXT_GREEDY) begin
            pending_r <= sres.next_st[fin_act];
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      explore_r <= in_rand_uniform < eps_r;
      rpick_r   <= in_rand_pick;
      oor_r     <= int'(src_in) >= NUM_STATES;
      q_addr_r  <= Q_AW'(int'(src_in) * SWEEP_LEN);
      tr_addr_r <= TR_AW'(int'(src_in) * NUM_ACTIONS);
      if (!sel_kind) begin
        out_action_r   <= '0;
        out_ns_r       <= '0;
        out_explored_r <= 1'b0;
        out_status_r   <= STATUS_ACK;
      end
    end else if (state_r == ST_SWEEP) begin
      q_addr_r <= q_addr_r + Q_AW'(1);
      if (obj_last) begin
        tr_addr_r <= tr_addr_r + TR_AW'(1);
      end
    end else if (state_r == ST_FINISH) begin
      if (fin_none) begin
        out_action_r   <= '0;
        out_ns_r       <= '0;
        out_explored_r <= 1'b0;
        out_status_r   <= STATUS_NO_ACTION;
      end else begin
        out_action_r   <= ACTION_W'(fin_act);
        out_ns_r       <= sres.next_st[fin_act];
        out_explored_r <= rand_mode;
        out_status_r   <= STATUS_OK;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_action = out_action_r;
  assign out_next_state    = out_ns_r;
  assign out_explored      = out_explored_r;
  assign out_status        = out_status_r;

  // ---------------- assertions ----------------
  localparam int SEL_LAT = SWEEP_LEN + 4;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while a command is in progress");

  a_ack_next: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ack_kind) |=> out_valid && out_status == STATUS_ACK)
    else $error("acknowledge missing after load or epsilon command");

  a_sel_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && sel_kind) |-> ##SEL_LAT (out_valid && out_status != STATUS_ACK))
    else $error("selection result not delivered at fixed latency");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_OK) |->
      (out_chosen_action == '0 && out_next_state == '0 && !out_explored))
    else $error("payload not cleared on failed or acknowledge result");

endmodule
